FILE: rtl/core/vmt_pkg.sv
package vmt_pkg;

    localparam int CW    = 32;            // coordinate width
    localparam int DW    = CW + 1;        // magnitude of a coordinate difference
    localparam int SQW   = 2 * DW;        // square of a difference
    localparam int SUMW  = 2 * CW + 2;    // sum of three squares, even width
    localparam int ROOTW = SUMW / 2;      // floor root of the sum
    localparam int RMW   = ROOTW + 3;     // root remainder
    localparam int NUMW  = 2 * CW + 1;    // difference times step
    localparam int DRW   = DW + 1;        // division remainder
    localparam int AXES  = 3;

    localparam logic [1:0] DIMS_2D    = 2'd2;
    localparam logic [1:0] DIMS_RESET = 2'd3;

    typedef struct packed {
        logic signed [CW-1:0] cur_x;
        logic signed [CW-1:0] cur_y;
        logic signed [CW-1:0] cur_z;
        logic signed [CW-1:0] goal_x;
        logic signed [CW-1:0] goal_y;
        logic signed [CW-1:0] goal_z;
        logic [CW-1:0]        step_length;
    } vmt_in_t;

    typedef struct packed {
        logic signed [CW-1:0] new_x;
        logic signed [CW-1:0] new_y;
        logic signed [CW-1:0] new_z;
        logic                 reached;
    } vmt_out_t;

    // what travels beside the arithmetic down the whole chain
    typedef struct packed {
        logic [AXES-1:0][CW-1:0] cur;
        logic [AXES-1:0][CW-1:0] goal;
        logic [AXES-1:0]         neg;
        logic                    reached;
        logic                    two_d;
    } vmt_side_t;

    typedef struct packed {
        vmt_side_t                 side;
        logic [AXES-1:0][NUMW-1:0] num;
        logic [SUMW-1:0]           rad;
        logic [RMW-1:0]            rem;
        logic [ROOTW-1:0]          root;
    } vmt_sq_t;

    typedef struct packed {
        vmt_side_t                side;
        logic [ROOTW-1:0]         root_len;
        logic [AXES-1:0][DRW-1:0] rem;
        logic [AXES-1:0][CW-1:0]  low;
    } vmt_dv_t;

endpackage

FILE: rtl/core/vmt_sqrt_cell.sv
module vmt_sqrt_cell
    import vmt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    en,
    input  logic    prev_valid,
    input  vmt_sq_t prev_data,
    output logic    next_valid,
    output vmt_sq_t next_data
);

    logic    valid_reg;
    vmt_sq_t data_reg;
    vmt_sq_t data_next;
    logic [RMW-1:0] rem_sh;
    logic [RMW-1:0] trial;

    // one root bit: bring down two radicand bits, try root*4+1
    always_comb
    begin
        rem_sh    = {prev_data.rem[RMW-3:0], prev_data.rad[SUMW-1 -: 2]};
        trial     = {1'b0, prev_data.root, 2'b01};
        data_next = prev_data;
        data_next.rad = {prev_data.rad[SUMW-3:0], 2'b00};
        if (rem_sh >= trial)
        begin
            data_next.rem  = rem_sh - trial;
            data_next.root = {prev_data.root[ROOTW-2:0], 1'b1};
        end
        else
        begin
            data_next.rem  = rem_sh;
            data_next.root = {prev_data.root[ROOTW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= prev_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign next_valid = valid_reg;
    assign next_data  = data_reg;

endmodule

FILE: rtl/core/vmt_div_cell.sv
module vmt_div_cell
    import vmt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    en,
    input  logic    prev_valid,
    input  vmt_dv_t prev_data,
    output logic    next_valid,
    output vmt_dv_t next_data
);

    logic    valid_reg;
    vmt_dv_t data_reg;
    vmt_dv_t data_next;
    logic [DRW-1:0] rem_sh;
    logic [DRW-1:0] divisor;

    // one quotient bit per axis; quotient bits fill the low word from the right
    always_comb
    begin
        data_next = prev_data;
        divisor   = DRW'(prev_data.root_len);
        rem_sh    = '0;
        for (int a = 0; a < AXES; a++)
        begin
            rem_sh = {prev_data.rem[a][DRW-2:0], prev_data.low[a][CW-1]};
            if (rem_sh >= divisor)
            begin
                data_next.rem[a] = rem_sh - divisor;
                data_next.low[a] = {prev_data.low[a][CW-2:0], 1'b1};
            end
            else
            begin
                data_next.rem[a] = rem_sh;
                data_next.low[a] = {prev_data.low[a][CW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= prev_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign next_valid = valid_reg;
    assign next_data  = data_reg;

endmodule

FILE: rtl/core/vector_move_towards_step.sv
// Channel   Direction  Handshake              Beat
// in        input      in_valid / in_stall    vmt_in_t  (current, goal, step)
// out       output     out_valid / out_stall  vmt_out_t (moved point, reached)
// cfg       input      cfg_write_en           cfg_write_data (dimensions)
//
// One beat enters per cycle unless in_stall is high; each accepted beat passes
// through the input register, square stage, sum/compare stage, 33 root cells,
// 32 divider cells and the output register. The root chain (one bit per cell)
// and the divider chain (one quotient bit per cell) make up most of that path.
// Reset clears every valid bit and sets dimensions to 3.
// The chain advances as one; it holds only while out_valid waits under
// out_stall, and in_stall is raised in exactly those cycles.
module vector_move_towards_step
    import vmt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  vmt_in_t    in_data,
    output logic       out_valid,
    input  logic       out_stall,
    output vmt_out_t   out_data,
    input  logic       cfg_write_en,
    input  logic [1:0] cfg_write_data
);

    logic       en;
    logic [1:0] dims_reg;

    // Dimensions register; any code but two means 3-D
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dims_reg <= DIMS_RESET;
        else if (cfg_write_en)
            dims_reg <= cfg_write_data;
    end

    assign en       = !out_valid || !out_stall;
    assign in_stall = !en;

    // Stage 1: take the beat, form signed differences and their magnitudes.
    logic [AXES-1:0][CW-1:0] cur_w, goal_w;
    logic [AXES-1:0][DW-1:0] diff_w, mag_w;
    logic [AXES-1:0]         neg_w;
    logic                    two_d_w;

    always_comb
    begin
        two_d_w = (dims_reg == DIMS_2D);
        cur_w   = {in_data.cur_x, in_data.cur_y, in_data.cur_z};
        goal_w  = {in_data.goal_x, in_data.goal_y, in_data.goal_z};
        // packed order: index 2 = x, 1 = y, 0 = z
        for (int a = 0; a < AXES; a++)
        begin
            diff_w[a] = {goal_w[a][CW-1], goal_w[a]} - {cur_w[a][CW-1], cur_w[a]};
            if (a == 0 && two_d_w)
                diff_w[a] = '0;
            neg_w[a] = diff_w[a][DW-1];
            mag_w[a] = neg_w[a] ? DW'(-diff_w[a]) : diff_w[a];
        end
    end

    logic                    v1_reg;
    vmt_side_t               side1_reg;
    logic [AXES-1:0][DW-1:0] mag1_reg;
    logic [CW-1:0]           step1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side1_reg.cur     <= cur_w;
            side1_reg.goal    <= goal_w;
            side1_reg.neg     <= neg_w;
            side1_reg.reached <= 1'b0;
            side1_reg.two_d   <= two_d_w;
            mag1_reg          <= mag_w;
            step1_reg         <= in_data.step_length;
        end
    end

    // Stage 2: squares, step squared and the three numerators.
    logic                      v2_reg;
    vmt_side_t                 side2_reg;
    logic [AXES-1:0][SQW-1:0]  sq2_reg;
    logic [AXES-1:0][NUMW-1:0] num2_reg;
    logic [SQW-1:0]            ss2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side2_reg <= side1_reg;
            ss2_reg   <= SQW'(step1_reg) * SQW'(step1_reg);
            for (int a = 0; a < AXES; a++)
            begin
                sq2_reg[a]  <= SQW'(mag1_reg[a]) * SQW'(mag1_reg[a]);
                num2_reg[a] <= NUMW'(SQW'(mag1_reg[a]) * SQW'(step1_reg));
            end
        end
    end

    // Stage 3: sum the squares, decide whether the goal is in reach,
    // and load the root chain.
    logic [SUMW-1:0] sum_w;
    vmt_side_t       side3_w;
    logic            v3_reg;
    vmt_sq_t         sq3_reg;

    assign sum_w = SUMW'(sq2_reg[0]) + SUMW'(sq2_reg[1]) + SUMW'(sq2_reg[2]);

    always_comb
    begin
        side3_w         = side2_reg;
        side3_w.reached = (sum_w <= SUMW'(ss2_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (en)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq3_reg.side <= side3_w;
            sq3_reg.num  <= num2_reg;
            sq3_reg.rad  <= sum_w;
            sq3_reg.rem  <= '0;
            sq3_reg.root <= '0;
        end
    end

    // Root chain: one bit of floor(sqrt(sum)) per cell.
    logic    sq_v [ROOTW+1];
    vmt_sq_t sq_d [ROOTW+1];

    assign sq_v[0] = v3_reg;
    assign sq_d[0] = sq3_reg;

    for (genvar k = 0; k < ROOTW; k++)
    begin : g_sqrt
        vmt_sqrt_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .en         (en),
            .prev_valid (sq_v[k]),
            .prev_data  (sq_d[k]),
            .next_valid (sq_v[k+1]),
            .next_data  (sq_d[k+1])
        );
    end

    // Divider chain: the upper half of each numerator is already below the
    // distance, so only CW quotient bits remain.
    logic    dv_v [CW+1];
    vmt_dv_t dv_d [CW+1];
    vmt_dv_t dv0_w;

    always_comb
    begin
        dv0_w.side     = sq_d[ROOTW].side;
        dv0_w.root_len = sq_d[ROOTW].root;
        for (int a = 0; a < AXES; a++)
        begin
            dv0_w.rem[a] = DRW'(sq_d[ROOTW].num[a][NUMW-1:CW]);
            dv0_w.low[a] = sq_d[ROOTW].num[a][CW-1:0];
        end
    end

    assign dv_d[0] = dv0_w;
    assign dv_v[0] = sq_v[ROOTW];

    for (genvar k = 0; k < CW; k++)
    begin : g_div
        vmt_div_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .en         (en),
            .prev_valid (dv_v[k]),
            .prev_data  (dv_d[k]),
            .next_valid (dv_v[k+1]),
            .next_data  (dv_d[k+1])
        );
    end

    // Output: step each axis by the quotient, or return the goal; z is zero in 2-D.
    vmt_dv_t                 fin;
    logic [AXES-1:0][CW-1:0] moved_w;
    logic                    out_valid_reg;
    vmt_out_t                out_reg;

    always_comb
    begin
        fin = dv_d[CW];
        for (int a = 0; a < AXES; a++)
        begin
            if (fin.side.reached)
                moved_w[a] = fin.side.goal[a];
            else if (fin.side.neg[a])
                moved_w[a] = fin.side.cur[a] - fin.low[a];
            else
                moved_w[a] = fin.side.cur[a] + fin.low[a];
        end
        if (fin.side.two_d)
            moved_w[0] = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= dv_v[CW];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg.new_x   <= moved_w[2];
            out_reg.new_y   <= moved_w[1];
            out_reg.new_z   <= moved_w[0];
            out_reg.reached <= fin.side.reached;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

FILE: rtl/core/vmt_checker.sv
module vmt_checker
    import vmt_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_stall,
    input logic     out_valid,
    input logic     out_stall,
    input vmt_out_t out_data
);

    // the pipe freezes exactly when a finished beat waits
    a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("in_stall does not follow the output hold");

    a_fresh_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("output beat right after reset");

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output beat dropped under stall");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_data))
        else $error("output beat changed under stall");

endmodule

bind vector_move_towards_step vmt_checker u_vmt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
